// ===== src/ptd_pkg.sv =====
// Shared types, codes and character tables for the packed text decoder.
package ptd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_ABBR = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Alphabet selections
  localparam logic [1:0] ALPHA_LOWER = 2'd0;
  localparam logic [1:0] ALPHA_UPPER = 2'd1;
  localparam logic [1:0] ALPHA_PUNCT = 2'd2;

  // Escape phases
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  // Special codes
  localparam logic [4:0] CODE_SPACE       = 5'd0;
  localparam logic [4:0] CODE_ABBR_MAX    = 5'd3;
  localparam logic [4:0] CODE_SHIFT_UPPER = 5'd4;
  localparam logic [4:0] CODE_SHIFT_PUNCT = 5'd5;
  localparam logic [4:0] CODE_FIRST_GLYPH = 5'd6;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  // Number of codes packed into one text word
  localparam int unsigned CODES_PER_WORD = 3;

  // Punctuation alphabet, indexed by code minus six
  localparam logic [7:0] PUNCT_GLYPH [26] = '{
    8'h20, 8'h0A, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h2E, 8'h2C, 8'h21, 8'h3F, 8'h5F, 8'h23,
    8'h27, 8'h22, 8'h2F, 8'h5C, 8'h2D, 8'h3A, 8'h28, 8'h29
  };

  // Decoding state of one string context
  typedef struct packed {
    logic [1:0] alphabet_sel;
    logic [1:0] escape_phase;
    logic [4:0] escape_high;
    logic [1:0] abbrev_pending;
  } ctx_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [9:0]  char_code;
    logic [15:0] abbrev_entry_addr;
    logic        out_of_range;
    logic        last;
  } result_t;

  // Batch of results decoded from one word, handed to the result buffer
  typedef struct packed {
    logic          valid;
    logic [1:0]    count;
    result_t [2:0] slot;
  } batch_t;

  // Result buffer status towards the decode stage
  typedef struct packed {
    logic       can_load;
    logic [1:0] pending;
  } buf_status_t;

endpackage

// ===== src/ptd_code_step.sv =====
// Decode of one 5-bit text code against the state of its context.
module ptd_code_step (
  input  ptd_pkg::ctx_t    ctx_in,
  input  logic [4:0]       code,
  input  logic [15:0]      abbrev_table_base,
  output ptd_pkg::ctx_t    ctx_out,
  output logic             emit,
  output ptd_pkg::result_t res
);

  logic [4:0] glyph_idx;
  logic [1:0] alpha_eff;
  logic [7:0] glyph;
  logic [1:0] pend_m1;
  logic [6:0] abbr_idx;

  assign glyph_idx = code - ptd_pkg::CODE_FIRST_GLYPH;
  assign alpha_eff = (ctx_in.alphabet_sel == 2'd3) ? ptd_pkg::ALPHA_LOWER
                                                   : ctx_in.alphabet_sel;
  assign pend_m1   = ctx_in.abbrev_pending - 2'd1;
  assign abbr_idx  = {pend_m1, code};

  // Look up the glyph of the current alphabet
  always_comb begin
    unique case (alpha_eff)
      ptd_pkg::ALPHA_UPPER: glyph = ptd_pkg::CHAR_UPPER_A + {3'b000, glyph_idx};
      ptd_pkg::ALPHA_PUNCT: glyph = ptd_pkg::PUNCT_GLYPH[glyph_idx];
      default:              glyph = ptd_pkg::CHAR_LOWER_A + {3'b000, glyph_idx};
    endcase
  end

  // Apply escape, abbreviation, shift and print rules in priority order
  always_comb begin
    ctx_out = ctx_in;
    emit    = 1'b0;
    res     = '0;
    if (ctx_in.escape_phase == ptd_pkg::ESC_HIGH) begin
      ctx_out.escape_high  = code;
      ctx_out.escape_phase = ptd_pkg::ESC_LOW;
    end else if (ctx_in.escape_phase[1]) begin
      emit                 = 1'b1;
      res.result_kind      = ptd_pkg::KIND_CHAR;
      res.char_code        = {ctx_in.escape_high, code};
      res.out_of_range     = |ctx_in.escape_high[4:3];
      ctx_out.escape_phase = ptd_pkg::ESC_NONE;
    end else if (ctx_in.abbrev_pending != 2'd0) begin
      emit                   = 1'b1;
      res.result_kind        = ptd_pkg::KIND_ABBR;
      res.abbrev_entry_addr  = abbrev_table_base + {8'h00, abbr_idx, 1'b0};
      ctx_out.abbrev_pending = 2'd0;
    end else if (code == ptd_pkg::CODE_SPACE) begin
      emit            = 1'b1;
      res.result_kind = ptd_pkg::KIND_CHAR;
      res.char_code   = {2'b00, ptd_pkg::CHAR_SPACE};
    end else if (code <= ptd_pkg::CODE_ABBR_MAX) begin
      ctx_out.abbrev_pending = code[1:0];
    end else if (code == ptd_pkg::CODE_SHIFT_UPPER) begin
      ctx_out.alphabet_sel = ptd_pkg::ALPHA_UPPER;
    end else if (code == ptd_pkg::CODE_SHIFT_PUNCT) begin
      ctx_out.alphabet_sel = ptd_pkg::ALPHA_PUNCT;
    end else begin
      ctx_out.alphabet_sel = ptd_pkg::ALPHA_LOWER;
      if (alpha_eff == ptd_pkg::ALPHA_PUNCT && code == ptd_pkg::CODE_FIRST_GLYPH) begin
        ctx_out.escape_phase = ptd_pkg::ESC_HIGH;
      end else begin
        emit            = 1'b1;
        res.result_kind = ptd_pkg::KIND_CHAR;
        res.char_code   = {2'b00, glyph};
      end
    end
  end

endmodule

// ===== src/ptd_result_buf.sv =====
// Three-slot result buffer that drains one result per cycle while out_ready is high.
module ptd_result_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptd_pkg::batch_t      batch,
  output ptd_pkg::buf_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ptd_pkg::result_t     out_res
);

  ptd_pkg::result_t [2:0] slot_r, slot_nxt;
  logic [1:0]             rem_r, rem_nxt;
  logic                   pop;

  assign pop             = out_valid && out_ready;
  assign out_valid       = (rem_r != 2'd0);
  assign out_res         = slot_r[0];
  assign status.can_load = (rem_r == 2'd0) || (rem_r == 2'd1 && out_ready);
  assign status.pending  = rem_r;

  // Load a new batch, or shift the queue down on each taken result
  always_comb begin
    slot_nxt = slot_r;
    rem_nxt  = rem_r;
    if (batch.valid) begin
      slot_nxt = batch.slot;
      rem_nxt  = batch.count;
    end else if (pop) begin
      slot_nxt = {slot_r[2], slot_r[2], slot_r[1]};
      rem_nxt  = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

// ===== src/packed_text_decoder_core.sv =====
// Top level of the packed text decoder: input register, word decode, result buffer.
//
// Usage: each input transaction carries one 16-bit text word and a context select
// (main string or abbreviation string). The word's three 5-bit codes are decoded
// in one pass and give zero to three result transactions: characters,
// abbreviation entry addresses, or a single end marker when an ending word
// yields nothing else. The last result of an ending word has last set.
// A word is registered on acceptance, then decoded and loaded into the result
// buffer once the buffer can take it. One word per cycle is taken when each word
// gives one result and the receiver does not stall; otherwise the next word waits
// until the single result channel, which drains the buffer one result per cycle
// while out_ready is high, takes the last result. The table base is written
// through cfg_we/cfg_wdata; the user must do so only while the block is idle, as
// the block does not enforce it. Reset clears both contexts, the table base, the
// input register and the buffer. When the receiver stalls, results hold in the
// buffer and one further word waits in the input register before in_ready falls.
module packed_text_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_word,
  input  logic        in_context_sel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [9:0]  out_char_code,
  output logic [15:0] out_abbrev_entry_addr,
  output logic        out_out_of_range,
  output logic        out_last
);

  logic                 in_valid_r, in_valid_nxt;
  logic [15:0]          word_r;
  logic                 sel_r;
  logic [15:0]          base_r;
  ptd_pkg::ctx_t        ctx_r [2];
  ptd_pkg::ctx_t        ctx_nxt;
  ptd_pkg::ctx_t        step_ctx [4];
  logic [2:0]           step_emit;
  ptd_pkg::result_t     step_res [3];
  ptd_pkg::batch_t      batch;
  ptd_pkg::buf_status_t buf_status;
  ptd_pkg::result_t     out_res;
  logic                 load_fire;
  logic                 word_end;
  logic [1:0]           n_emit;

  assign load_fire    = in_valid_r && buf_status.can_load;
  assign in_ready     = !in_valid_r || load_fire;
  assign in_valid_nxt = (in_valid && in_ready) || (in_valid_r && !load_fire);
  assign word_end     = word_r[15];

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_code_word;
      sel_r  <= in_context_sel;
    end
  end

  // Table base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 16'h0000;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  // Chain the three code decodes, high code first
  assign step_ctx[0] = ctx_r[sel_r];

  for (genvar g = 0; g < ptd_pkg::CODES_PER_WORD; g++) begin : g_step
    ptd_code_step u_step (
      .ctx_in            (step_ctx[g]),
      .code              (word_r[14-5*g -: 5]),
      .abbrev_table_base (base_r),
      .ctx_out           (step_ctx[g+1]),
      .emit              (step_emit[g]),
      .res               (step_res[g])
    );
  end

  assign n_emit  = {1'b0, step_emit[0]} + {1'b0, step_emit[1]} + {1'b0, step_emit[2]};
  assign ctx_nxt = word_end ? '0 : step_ctx[3];

  // Pack emitted results into order and mark the end of string
  always_comb begin
    batch       = '0;
    batch.valid = load_fire;
    batch.count = n_emit;
    if (step_emit[0]) begin
      batch.slot[0] = step_res[0];
      batch.slot[1] = step_emit[1] ? step_res[1] : step_res[2];
    end else begin
      batch.slot[0] = step_emit[1] ? step_res[1] : step_res[2];
      batch.slot[1] = step_res[2];
    end
    batch.slot[2] = step_res[2];
    if (word_end) begin
      if (n_emit == 2'd0) begin
        batch.count                 = 2'd1;
        batch.slot[0]               = '0;
        batch.slot[0].result_kind   = ptd_pkg::KIND_END;
        batch.slot[0].last          = 1'b1;
      end else begin
        batch.slot[n_emit - 2'd1].last = 1'b1;
      end
    end
  end

  // Advance the context state of the loaded word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r[0] <= '0;
      ctx_r[1] <= '0;
    end else if (load_fire) begin
      ctx_r[sel_r] <= ctx_nxt;
    end
  end

  ptd_result_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .batch     (batch),
    .status    (buf_status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_result_kind       = out_res.result_kind;
  assign out_char_code         = out_res.char_code;
  assign out_abbrev_entry_addr = out_res.abbrev_entry_addr;
  assign out_out_of_range      = out_res.out_of_range;
  assign out_last              = out_res.last;

`ifndef ASSERT_OFF
  // A loaded ending word always holds at least one result
  a_batch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire && word_end |-> batch.count != 2'd0)
    else $error("empty result batch loaded for an ending word");

  // An ending word leaves its context cleared
  a_end_clears_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire && word_end |=> ctx_r[$past(sel_r)] == '0)
    else $error("context not cleared after end of string");

  // An end marker is always the last result of its word
  a_end_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == ptd_pkg::KIND_END |-> out_last)
    else $error("end marker without last");

  // A held word that the buffer cannot take blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !buf_status.can_load |-> !in_ready && buf_status.pending != 2'd0)
    else $error("input accepted while buffer full");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for packed_text_decoder_core: directed and random text words.
`timescale 1ns / 1ps

module tb;

  // Abbreviation set codes
  localparam logic [4:0] CODE_ABBR_1 = 5'd1;
  localparam logic [4:0] CODE_ABBR_2 = 5'd2;
  localparam logic [4:0] CODE_ABBR_3 = 5'd3;

  // Cycles to let a word that yields nothing clear the pipeline
  localparam int SETTLE_CYCLES = 10;

  // Punctuation alphabet, from code six upwards
  localparam string PUNCT_CHARS = " \n0123456789.,!?_#'\"/\\-:()";

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_code_word;
  logic        in_context_sel;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [9:0]  out_char_code;
  logic [15:0] out_abbrev_entry_addr;
  logic        out_out_of_range;
  logic        out_last;

  // Predicted decoder state
  ptd_pkg::ctx_t    text_ctx [2];
  logic [15:0]      table_base;
  ptd_pkg::result_t decoded_results [$];
  logic [4:0]       sentence_codes [$];

  // Run control and tallies
  bit               gaps_on;
  bit               stalls_on;
  int               stall_left;
  int               mismatches;
  int               words_sent;
  int               results_checked;
  int               bases_written;
  ptd_pkg::result_t want;

  packed_text_decoder_core u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_code_word          (in_code_word),
    .in_context_sel        (in_context_sel),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_result_kind       (out_result_kind),
    .out_char_code         (out_char_code),
    .out_abbrev_entry_addr (out_abbrev_entry_addr),
    .out_out_of_range      (out_out_of_range),
    .out_last              (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40)
      $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pack(input logic fin, input logic [4:0] c0,
                                       input logic [4:0] c1, input logic [4:0] c2);
    return {fin, c0, c1, c2};
  endfunction

  // Append one code to the end of the string buffer
  function automatic void add_code(input logic [4:0] code);
    sentence_codes.insert(sentence_codes.size(), code);
  endfunction

  function automatic logic [7:0] glyph_of(input logic [1:0] alpha, input logic [4:0] code);
    logic [4:0] idx;
    idx = code - ptd_pkg::CODE_FIRST_GLYPH;
    case (alpha)
      ptd_pkg::ALPHA_UPPER: return ptd_pkg::CHAR_UPPER_A + 8'(idx);
      ptd_pkg::ALPHA_PUNCT: return PUNCT_CHARS[idx];
      default:              return ptd_pkg::CHAR_LOWER_A + 8'(idx);
    endcase
  endfunction

  // Decode one 5-bit code in the selected context; returns 1 when it yields a result
  function automatic bit decode_code(input logic sel, input logic [4:0] code,
                                     output ptd_pkg::result_t res);
    ptd_pkg::ctx_t c;
    logic [1:0]    alpha;
    logic [1:0]    set_m1;
    bit            hit;
    c   = text_ctx[sel];
    res = '0;
    hit = 1'b0;
    if (c.escape_phase == ptd_pkg::ESC_HIGH) begin
      c.escape_high  = code;
      c.escape_phase = ptd_pkg::ESC_LOW;
    end else if (c.escape_phase != ptd_pkg::ESC_NONE) begin
      res.result_kind  = ptd_pkg::KIND_CHAR;
      res.char_code    = {c.escape_high, code};
      res.out_of_range = (res.char_code > 10'd255);
      c.escape_phase   = ptd_pkg::ESC_NONE;
      hit = 1'b1;
    end else if (c.abbrev_pending != 2'd0) begin
      set_m1 = c.abbrev_pending - 2'd1;
      res.result_kind       = ptd_pkg::KIND_ABBR;
      res.abbrev_entry_addr = table_base + {8'd0, set_m1, code, 1'b0};
      c.abbrev_pending = 2'd0;
      hit = 1'b1;
    end else if (code == ptd_pkg::CODE_SPACE) begin
      res.result_kind = ptd_pkg::KIND_CHAR;
      res.char_code   = {2'b00, ptd_pkg::CHAR_SPACE};
      hit = 1'b1;
    end else if (code <= ptd_pkg::CODE_ABBR_MAX) begin
      c.abbrev_pending = code[1:0];
    end else if (code == ptd_pkg::CODE_SHIFT_UPPER) begin
      c.alphabet_sel = ptd_pkg::ALPHA_UPPER;
    end else if (code == ptd_pkg::CODE_SHIFT_PUNCT) begin
      c.alphabet_sel = ptd_pkg::ALPHA_PUNCT;
    end else begin
      // Print from the current alphabet and drop the shift
      alpha = c.alphabet_sel;
      c.alphabet_sel = ptd_pkg::ALPHA_LOWER;
      if (alpha == ptd_pkg::ALPHA_PUNCT && code == ptd_pkg::CODE_FIRST_GLYPH) begin
        c.escape_phase = ptd_pkg::ESC_HIGH;
      end else begin
        res.result_kind = ptd_pkg::KIND_CHAR;
        res.char_code   = {2'b00, glyph_of(alpha, code)};
        hit = 1'b1;
      end
    end
    text_ctx[sel] = c;
    return hit;
  endfunction

  // Work out the results of one accepted word and queue them
  function automatic void decode_word(input logic [15:0] word, input logic sel);
    ptd_pkg::result_t word_results [3];
    ptd_pkg::result_t res;
    int               n;
    int               i;
    n = 0;
    for (i = 0; i < ptd_pkg::CODES_PER_WORD; i++) begin
      if (decode_code(sel, word[14 - 5 * i -: 5], res)) begin
        word_results[n] = res;
        n++;
      end
    end
    if (word[15]) begin
      text_ctx[sel] = '0;
      if (n == 0) begin
        word_results[0] = '0;
        word_results[0].result_kind = ptd_pkg::KIND_END;
        n = 1;
      end
      word_results[n - 1].last = 1'b1;
    end
    for (i = 0; i < n; i++)
      decoded_results.insert(decoded_results.size(), word_results[i]);
  endfunction

  // Hold the word until accepted, then predict and maybe idle
  task automatic send_word(input logic [15:0] word, input logic sel);
    int idle;
    in_valid       <= 1'b1;
    in_code_word   <= word;
    in_context_sel <= sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_word(word, sel);
    words_sent++;
    idle = gaps_on ? pick_gap() : 0;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Drain all results and let a trailing empty word clear
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_base(input logic [15:0] base);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we    <= 1'b0;
    table_base = base;
    bases_written++;
  endtask

  // Append one token of a plausible string to the code buffer
  task automatic add_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      add_code(5'($urandom_range(ptd_pkg::CODE_FIRST_GLYPH, 31)));
    end else if (r < 50) begin
      add_code(ptd_pkg::CODE_SPACE);
    end else if (r < 60) begin
      add_code(ptd_pkg::CODE_SHIFT_UPPER);
      add_code(5'($urandom_range(ptd_pkg::CODE_FIRST_GLYPH, 31)));
    end else if (r < 72) begin
      add_code(ptd_pkg::CODE_SHIFT_PUNCT);
      add_code(5'($urandom_range(ptd_pkg::CODE_FIRST_GLYPH + 1, 31)));
    end else if (r < 82) begin
      add_code(ptd_pkg::CODE_SHIFT_PUNCT);
      add_code(ptd_pkg::CODE_FIRST_GLYPH);
      add_code(5'($urandom));
      add_code(5'($urandom));
    end else if (r < 92) begin
      add_code(5'($urandom_range(CODE_ABBR_1, ptd_pkg::CODE_ABBR_MAX)));
      add_code(5'($urandom));
    end else begin
      add_code(5'($urandom));
    end
  endtask

  // Send one string in one context, now and then with stray words or no end
  task automatic send_sentence(input logic sel);
    int         tokens;
    int         i;
    logic [4:0] c0, c1, c2;
    logic       fin;
    sentence_codes.delete();
    tokens = $urandom_range(1, 9);
    for (i = 0; i < tokens; i++) add_token();
    while (sentence_codes.size() % ptd_pkg::CODES_PER_WORD != 0)
      add_code($urandom_range(0, 1) ? ptd_pkg::CODE_SHIFT_UPPER
                                    : ptd_pkg::CODE_SHIFT_PUNCT);
    while (sentence_codes.size() != 0) begin
      c0 = sentence_codes.pop_front();
      c1 = sentence_codes.pop_front();
      c2 = sentence_codes.pop_front();
      fin = (sentence_codes.size() == 0) && ($urandom_range(0, 9) != 0);
      send_word(pack(fin, c0, c1, c2), sel);
      if ($urandom_range(0, 9) == 0)
        send_word(16'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_letters_and_space();
    // ' ', a, z
    send_word(pack(1'b0, ptd_pkg::CODE_SPACE, 5'd6, 5'd31), 1'b0);
    // A, shift held
    send_word(pack(1'b0, ptd_pkg::CODE_SHIFT_UPPER, 5'd6, ptd_pkg::CODE_SHIFT_UPPER), 1'b0);
    // space keeps shift: Z, b
    send_word(pack(1'b0, ptd_pkg::CODE_SPACE, 5'd31, 5'd7), 1'b0);
  endtask

  task automatic test_punctuation();
    // newline
    send_word(pack(1'b0, ptd_pkg::CODE_SHIFT_PUNCT, 5'd7, ptd_pkg::CODE_SHIFT_PUNCT), 1'b0);
    // double quote, ')'
    send_word(pack(1'b0, 5'd25, ptd_pkg::CODE_SHIFT_PUNCT, 5'd31), 1'b0);
    // single quote, c
    send_word(pack(1'b0, ptd_pkg::CODE_SHIFT_PUNCT, 5'd24, 5'd8), 1'b0);
  endtask

  task automatic test_escapes();
    // 255 stays in range, 256 and 1023 are flagged
    send_word(pack(1'b0, ptd_pkg::CODE_SHIFT_PUNCT, ptd_pkg::CODE_FIRST_GLYPH, 5'd7), 1'b0);
    send_word(pack(1'b0, 5'd31, ptd_pkg::CODE_SHIFT_PUNCT, ptd_pkg::CODE_FIRST_GLYPH), 1'b0);
    send_word(pack(1'b0, 5'd8, 5'd0, ptd_pkg::CODE_SHIFT_PUNCT), 1'b0);
    send_word(pack(1'b0, ptd_pkg::CODE_FIRST_GLYPH, 5'd31, 5'd31), 1'b0);
  endtask

  task automatic test_abbreviations();
    send_word(pack(1'b0, CODE_ABBR_1, 5'd0, CODE_ABBR_2), 1'b0);
    send_word(pack(1'b0, 5'd31, CODE_ABBR_3, 5'd31), 1'b0);
    // abbreviation leaves the pending shift in place
    send_word(pack(1'b0, ptd_pkg::CODE_SHIFT_UPPER, CODE_ABBR_1, 5'd6), 1'b0);
    send_word(pack(1'b0, 5'd7, ptd_pkg::CODE_SPACE, ptd_pkg::CODE_SPACE), 1'b0);
  endtask

  task automatic test_table_wrap();
    write_table_base(16'hFFFF);
    send_word(pack(1'b1, CODE_ABBR_3, 5'd31, ptd_pkg::CODE_SPACE), 1'b1);
  endtask

  task automatic test_string_end();
    // end alone
    send_word(pack(1'b1, ptd_pkg::CODE_SHIFT_UPPER, ptd_pkg::CODE_SHIFT_PUNCT, CODE_ABBR_1),
              1'b0);
    // armed abbreviation dropped
    send_word(pack(1'b1, 5'd6, 5'd6, CODE_ABBR_2), 1'b0);
    // mid-escape end
    send_word(pack(1'b1, ptd_pkg::CODE_SHIFT_PUNCT, ptd_pkg::CODE_FIRST_GLYPH, 5'd3), 1'b0);
    send_word(pack(1'b0, 5'd6, ptd_pkg::CODE_SPACE, ptd_pkg::CODE_SPACE), 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h8000, 1'b1);
  endtask

  task automatic test_contexts();
    send_word(pack(1'b0, ptd_pkg::CODE_SHIFT_UPPER, ptd_pkg::CODE_SHIFT_PUNCT,
                   ptd_pkg::CODE_FIRST_GLYPH), 1'b0);
    send_word(pack(1'b0, 5'd6, ptd_pkg::CODE_SHIFT_UPPER, ptd_pkg::CODE_SPACE), 1'b1);
    send_word(pack(1'b0, 5'd2, 5'd0, ptd_pkg::CODE_SHIFT_PUNCT), 1'b0);
    send_word(pack(1'b1, 5'd6, ptd_pkg::CODE_SPACE, ptd_pkg::CODE_SPACE), 1'b1);
    send_word(pack(1'b1, 5'd13, ptd_pkg::CODE_SPACE, ptd_pkg::CODE_SPACE), 1'b0);
  endtask

  task automatic test_random_text(input logic [15:0] base, input bit gaps, input bit stalls,
                                  input int count);
    int goal;
    write_table_base(base);
    gaps_on   = gaps;
    stalls_on = stalls;
    goal = words_sent + count;
    while (words_sent < goal) send_sentence(1'($urandom_range(0, 1)));
  endtask

  // Receiver: random stalls when enabled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (decoded_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = decoded_results.pop_front();
        results_checked++;
        if (out_result_kind !== want.result_kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_result_kind, want.result_kind));
        if (out_char_code !== want.char_code)
          report_mismatch($sformatf("char 0x%03h, want 0x%03h", out_char_code, want.char_code));
        if (out_abbrev_entry_addr !== want.abbrev_entry_addr)
          report_mismatch($sformatf("addr 0x%04h, want 0x%04h",
                                    out_abbrev_entry_addr, want.abbrev_entry_addr));
        if (out_out_of_range !== want.out_of_range)
          report_mismatch($sformatf("out_of_range %b, want %b",
                                    out_out_of_range, want.out_of_range));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_last, want.last));
      end
    end
  end

  initial begin
    int spin;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 16'h0000;
    in_valid       <= 1'b0;
    in_code_word   <= 16'h0000;
    in_context_sel <= 1'b0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    text_ctx[0] = '0;
    text_ctx[1] = '0;
    table_base = 16'h0000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_letters_and_space();
    test_punctuation();
    test_escapes();
    test_abbreviations();
    test_table_wrap();
    test_string_end();
    test_contexts();
    test_random_text(16'($urandom), 1'b1, 1'b1, 45);
    test_random_text(16'h0000, 1'b0, 1'b0, 45);
    test_random_text(16'hFFC0, 1'b1, 1'b0, 45);
    test_random_text(16'($urandom), 1'b1, 1'b1, 45);

    // Drain and look for leftovers
    in_valid <= 1'b0;
    for (spin = 0; spin < 20000 && decoded_results.size() != 0; spin++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (decoded_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", decoded_results.size()));

    $display("Sent %0d text words over both contexts, checked %0d results, %0d table bases",
             words_sent, results_checked, bases_written);
    $display("Covered shifts, escapes in and out of range, abbreviations and string ends");
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ptd_pkg.sv
src/ptd_code_step.sv
src/ptd_result_buf.sv
src/packed_text_decoder_core.sv
bench/tb.sv
